@@ rtl/core/npcs_pkg.sv @@
// Package for the nearest palette color search block.
// Holds the palette size, derived widths, request codes and the controller/datapath types.
// No dependencies.
`default_nettype none

package npcs_pkg;

  localparam int ENTRIES    = 256;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CHAN_W     = 8;
  localparam int SLOT_W     = 8;
  localparam int DIST_W     = 10;
  localparam int DIST_START = 256 * 3;
  localparam int CMP_W      = ((IDX_W > SLOT_W) ? IDX_W : SLOT_W) + 1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic wr_en;
    logic load_query;
    logic rd_en;
    idx_t rd_addr;
    logic out_load;
    logic out_is_query;
  } npcs_cmd_t;

  typedef struct packed {
    logic out_free;
  } npcs_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/npcs_req_if.sv @@
// Request channel of the nearest palette color search block.
// Carries one write or query beat with valid/ready; no dependencies.
`default_nettype none

interface npcs_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, req_type, entry_index, red, green, blue, input ready);
  modport sink   (input valid, req_type, entry_index, red, green, blue, output ready);
endinterface

`default_nettype wire

@@ rtl/core/npcs_rsp_if.sv @@
// Response channel of the nearest palette color search block.
// Carries one result beat with valid/ready; no dependencies.
`default_nettype none

interface npcs_rsp_if;
  logic       valid;
  logic       ready;
  logic       is_query_result;
  logic [7:0] match_index;

  modport source (output valid, is_query_result, match_index, input ready);
  modport sink   (input valid, is_query_result, match_index, output ready);
endinterface

`default_nettype wire

@@ rtl/core/npcs_datapath.sv @@
// Datapath: palette memory with per-entry valid bits, distance compare,
// running minimum and the output register. Depends on npcs_pkg.
`default_nettype none

module npcs_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire npcs_pkg::npcs_cmd_t cmd,
  output      npcs_pkg::npcs_sts_t sts,
  input  wire logic [7:0]         entry_index,
  input  wire logic [7:0]         red,
  input  wire logic [7:0]         green,
  input  wire logic [7:0]         blue,
  output      logic               rsp_valid,
  input  wire logic               rsp_ready,
  output      logic               rsp_is_query,
  output      logic [7:0]         rsp_index
);
  import npcs_pkg::*;

  logic [3*CHAN_W-1:0] mem [ENTRIES];
  logic [ENTRIES-1:0]  vld;

  logic                in_range;
  idx_t                wr_addr;
  chan_t               q_r;
  chan_t               q_g;
  chan_t               q_b;
  logic [3*CHAN_W-1:0] rd_data;
  logic                rd_vld;
  logic                cmp_valid;
  idx_t                cmp_idx;
  chan_t               e_r;
  chan_t               e_g;
  chan_t               e_b;
  chan_t               d_r;
  chan_t               d_g;
  chan_t               d_b;
  dist_t               cur_dist;
  dist_t               best_dist;
  idx_t                best_idx;

  assign in_range = CMP_W'(entry_index) < CMP_W'(ENTRIES);
  assign wr_addr  = IDX_W'(entry_index);

  always_ff @(posedge clk) begin
    if (cmd.wr_en && in_range) begin
      mem[wr_addr] <= {red, green, blue};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[cmd.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      cmp_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cmd.wr_en && in_range) begin
        vld[wr_addr] <= 1'b1;
      end
      cmp_valid <= cmd.rd_en;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_vld  <= vld[cmd.rd_addr];
      cmp_idx <= cmd.rd_addr;
    end
  end

  // An entry never written reads as black.
  assign e_r = rd_vld ? rd_data[3*CHAN_W-1:2*CHAN_W] : '0;
  assign e_g = rd_vld ? rd_data[2*CHAN_W-1:CHAN_W]   : '0;
  assign e_b = rd_vld ? rd_data[CHAN_W-1:0]          : '0;

  assign d_r      = (q_r > e_r) ? (q_r - e_r) : (e_r - q_r);
  assign d_g      = (q_g > e_g) ? (q_g - e_g) : (e_g - q_g);
  assign d_b      = (q_b > e_b) ? (q_b - e_b) : (e_b - q_b);
  assign cur_dist = DIST_W'(d_r) + DIST_W'(d_g) + DIST_W'(d_b);

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      q_r       <= red;
      q_g       <= green;
      q_b       <= blue;
      best_dist <= DIST_W'(DIST_START);
      best_idx  <= '0;
    end else if (cmp_valid && (cur_dist < best_dist)) begin
      best_dist <= cur_dist;
      best_idx  <= cmp_idx;
    end
    if (cmd.out_load) begin
      rsp_is_query <= cmd.out_is_query;
      rsp_index    <= cmd.out_is_query ? SLOT_W'(best_idx) : '0;
    end
  end

  assign sts.out_free = !rsp_valid || rsp_ready;

endmodule

`default_nettype wire

@@ rtl/core/npcs_ctrl.sv @@
// Controller: accepts requests, sequences the palette scan and hands the
// result to the output register. Depends on npcs_pkg.
`default_nettype none

module npcs_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  input  wire logic                req_type,
  output      logic                req_ready,
  output      npcs_pkg::npcs_cmd_t cmd,
  input  wire npcs_pkg::npcs_sts_t sts
);
  import npcs_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH,
    S_FINISH
  } state_t;

  state_t state;
  idx_t   cnt;
  logic   is_query;
  logic   accept;
  logic   scan_last;

  assign req_ready = (state == S_IDLE);
  assign accept    = req_valid && req_ready;
  assign scan_last = (cnt == IDX_W'(ENTRIES - 1));

  always_comb begin
    cmd              = '0;
    cmd.wr_en        = accept && (req_type == REQ_WRITE);
    cmd.load_query   = accept && (req_type == REQ_QUERY);
    cmd.rd_en        = (state == S_SCAN);
    cmd.rd_addr      = cnt;
    cmd.out_load     = (state == S_FINISH) && sts.out_free;
    cmd.out_is_query = is_query;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      is_query <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          cnt <= '0;
          if (accept) begin
            is_query <= (req_type == REQ_QUERY);
            state    <= (req_type == REQ_QUERY) ? S_SCAN : S_FINISH;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          if (scan_last) begin
            state <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          state <= S_FINISH;
        end
        S_FINISH: begin
          if (sts.out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/nearest_palette_color_search.sv @@
// Top level of the nearest palette color search block.
// Depends on npcs_pkg, npcs_req_if, npcs_rsp_if, npcs_ctrl and npcs_datapath.
//
//   Channel  Direction  Beat contents
//   req      in         req_type, entry_index, red, green, blue
//   rsp      out        is_query_result, match_index
//
// A write waits in S_FINISH for the output register before the next request
// can be taken. A query scans in S_SCAN, then S_FLUSH and S_FINISH; the palette
// memory reads one entry per cycle for the distance compare during S_SCAN.
// After reset all palette entries read as zero through per-entry valid bits.
// A result waiting on rsp does not block acceptance of the next request; only
// the hand-off of a new result waits for the output register to free up.
`default_nettype none

module nearest_palette_color_search (
  input  wire logic  clk,
  input  wire logic  rst,
  npcs_req_if.sink   req,
  npcs_rsp_if.source rsp
);
  import npcs_pkg::*;

  npcs_cmd_t cmd;
  npcs_sts_t sts;

  npcs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_type  (req.req_type),
    .req_ready (req.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  npcs_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .entry_index  (req.entry_index),
    .red          (req.red),
    .green        (req.green),
    .blue         (req.blue),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_is_query (rsp.is_query_result),
    .rsp_index    (rsp.match_index)
  );

  // A write acknowledge always reports slot zero.
  a_write_ack_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.is_query_result) |-> (rsp.match_index == 8'd0))
    else $error("write acknowledge with nonzero index");

  // Every accepted request closes the input in the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("request accepted while previous one still in progress");

  // A query still keeps the input closed in the flush state after the scan.
  a_query_scan_busy: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.req_type) |=> ##(ENTRIES) !req.ready)
    else $error("query scan ended early");

  // A result is only handed off while no request is being taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !$rose(rsp.valid))
    else $error("result appeared one cycle after acceptance");

endmodule

`default_nettype wire

@@ bench/tb_nearest_palette_color_search.sv @@
// Testbench for nearest_palette_color_search: directed table, then random writes and queries.
// Expected results come from known table rows or a bench palette model; checked in order.
// Depends on npcs_pkg, npcs_req_if, npcs_rsp_if and the block's RTL.
`timescale 1ns / 100ps

module tb_nearest_palette_color_search;
  import npcs_pkg::*;

  localparam int   RANDOM_ITEMS = 930;
  localparam int   DRAIN_CYCLES = ENTRIES + 40;
  localparam int   NUM_ROWS     = 20;

  typedef struct packed {
    logic       is_query;
    logic [7:0] index;
  } answer_t;

  typedef struct {
    logic       kind;
    logic [7:0] slot;
    chan_t      red;
    chan_t      green;
    chan_t      blue;
    bit         known;
    logic [7:0] want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;

  npcs_req_if req_ch ();
  npcs_rsp_if rsp_ch ();

  nearest_palette_color_search dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [23:0] palette_model [ENTRIES];
  answer_t     pending_answers [$];
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          mismatch_count;
  int          writes_sent;
  int          queries_sent;
  int          answers_seen;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{REQ_QUERY, 8'h00, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{REQ_QUERY, 8'hFF, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
    '{REQ_WRITE, 8'hFF, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
    '{REQ_QUERY, 8'h00, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255},
    '{REQ_WRITE, 8'h00, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
    '{REQ_QUERY, 8'hAA, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
    '{REQ_WRITE, 8'h00, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{REQ_WRITE, 8'h80, 8'd128, 8'd64,  8'd32,  1'b1, 8'd0},
    '{REQ_QUERY, 8'h55, 8'd128, 8'd64,  8'd32,  1'b1, 8'd128},
    '{REQ_WRITE, 8'h40, 8'd128, 8'd64,  8'd32,  1'b1, 8'd0},
    '{REQ_QUERY, 8'h80, 8'd128, 8'd64,  8'd32,  1'b1, 8'd64},
    '{REQ_QUERY, 8'h01, 8'd130, 8'd60,  8'd40,  1'b0, 8'd0},
    '{REQ_WRITE, 8'hC8, 8'd10,  8'd250, 8'd5,   1'b1, 8'd0},
    '{REQ_QUERY, 8'hFE, 8'd0,   8'd255, 8'd0,   1'b0, 8'd0},
    '{REQ_WRITE, 8'h01, 8'd170, 8'd85,  8'd170, 1'b1, 8'd0},
    '{REQ_WRITE, 8'h02, 8'd85,  8'd170, 8'd85,  1'b1, 8'd0},
    '{REQ_QUERY, 8'h7F, 8'd127, 8'd127, 8'd127, 1'b0, 8'd0},
    '{REQ_QUERY, 8'h33, 8'd255, 8'd0,   8'd255, 1'b0, 8'd0},
    '{REQ_WRITE, 8'hFF, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
    '{REQ_QUERY, 8'hCC, 8'd255, 8'd255, 8'd255, 1'b0, 8'd0}
  };

  function automatic int abs_diff(int a, int b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic [7:0] nearest_slot(chan_t r, chan_t g, chan_t b);
    int best_dist;
    int best;
    int d;
    best_dist = DIST_START;
    best      = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      d = abs_diff(r, palette_model[i][23:16]) + abs_diff(g, palette_model[i][15:8])
        + abs_diff(b, palette_model[i][7:0]);
      if (d < best_dist) begin
        best_dist = d;
        best      = i;
      end
    end
    return best[7:0];
  endfunction

  function automatic answer_t predict_answer(logic kind, logic [7:0] slot,
                                             chan_t r, chan_t g, chan_t b);
    answer_t a;
    if (kind == REQ_WRITE) begin
      if (int'(slot) < ENTRIES) palette_model[slot] = {r, g, b};
      a = '{1'b0, 8'd0};
    end else begin
      a = '{1'b1, nearest_slot(r, g, b)};
    end
    return a;
  endfunction

  function automatic chan_t nudge(chan_t v, int d);
    int x;
    x = int'(v) + d;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return x[7:0];
  endfunction

  task automatic send_beat(logic kind, logic [7:0] slot, chan_t r, chan_t g, chan_t b,
                           bit known, logic [7:0] want);
    answer_t a;
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.req_type    <= kind;
    req_ch.entry_index <= slot;
    req_ch.red         <= r;
    req_ch.green       <= g;
    req_ch.blue        <= b;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    a = predict_answer(kind, slot, r, g, b);
    if (known) a = '{kind == REQ_QUERY, want};
    pending_answers.push_back(a);
    if (kind == REQ_WRITE) writes_sent++;
    else queries_sent++;
  endtask

  task automatic drain_answers();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic send_random_item();
    logic        kind;
    logic [7:0]  slot;
    chan_t       r;
    chan_t       g;
    chan_t       b;
    int          pick;
    logic [23:0] seen_color;
    kind       = 1'($urandom_range(1));
    slot       = 8'($urandom_range(255));
    pick       = $urandom_range(9);
    seen_color = palette_model[$urandom_range(ENTRIES - 1)];
    r = 8'($urandom_range(255));
    g = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    if (kind == REQ_WRITE) begin
      if (pick < 3) begin
        {r, g, b} = seen_color;
      end else if (pick < 5) begin
        r = $urandom_range(1) ? 8'hFF : 8'h00;
        g = $urandom_range(1) ? 8'hFF : 8'h00;
        b = $urandom_range(1) ? 8'hFF : 8'h00;
      end
    end else if (pick >= 7) begin
      {r, g, b} = seen_color;
    end else if (pick >= 3) begin
      r = nudge(seen_color[23:16], int'($urandom_range(8)) - 4);
      g = nudge(seen_color[15:8], int'($urandom_range(8)) - 4);
      b = nudge(seen_color[7:0], int'($urandom_range(8)) - 4);
    end
    send_beat(kind, slot, r, g, b, 1'b0, 8'd0);
  endtask

  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : check_answers
    answer_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat: expected none, got is_query=%0b index=%0d",
                 $time, rsp_ch.is_query_result, rsp_ch.match_index);
      end else begin
        want = pending_answers.pop_front();
        if (rsp_ch.is_query_result !== want.is_query || rsp_ch.match_index !== want.index) begin
          mismatch_count++;
          $display("%0t: mismatch: expected is_query=%0b index=%0d, got is_query=%0b index=%0d",
                   $time, want.is_query, want.index, rsp_ch.is_query_result,
                   rsp_ch.match_index);
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("** nearest_palette_color_search: FAILED **");
    $finish;
  end

  initial begin
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.req_type    = REQ_WRITE;
    req_ch.entry_index = 8'd0;
    req_ch.red         = 8'd0;
    req_ch.green       = 8'd0;
    req_ch.blue        = 8'd0;
    rsp_ch.ready       = 1'b0;
    tx_idle_pct        = 18;
    rx_idle_pct        = 54;
    mismatch_count     = 0;
    writes_sent        = 0;
    queries_sent       = 0;
    answers_seen       = 0;
    foreach (palette_model[i]) palette_model[i] = 24'd0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      send_beat(directed_rows[i].kind, directed_rows[i].slot, directed_rows[i].red,
                directed_rows[i].green, directed_rows[i].blue, directed_rows[i].known,
                directed_rows[i].want);
    end
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        drain_answers();
        tx_idle_pct = 54;
        rx_idle_pct = 18;
      end else if (i == 2 * RANDOM_ITEMS / 3) begin
        drain_answers();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_random_item();
    end
    drain_answers();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d palette writes and %0d nearest-color queries; %0d result beats checked",
             writes_sent, queries_sent, answers_seen);
    $display("across three sender/receiver idle mixes with %0d mismatches.", mismatch_count);
    if (mismatch_count == 0) begin
      $display("** nearest_palette_color_search: PASSED **");
    end else begin
      $display("** nearest_palette_color_search: FAILED **");
    end
    $finish;
  end

endmodule
